@@ rtl/core/bfr_pkg.sv @@
// Package for the bitmap font text renderer: glyph geometry, font store sizing,
// request op codes, configuration register indexes and the address unit control struct.
// No dependencies.
`default_nettype none
package bfr_pkg;

	localparam int GLYPH_HEIGHT = 16;
	localparam int GLYPH_WIDTH  = 8;
	localparam int FONT_BYTES   = 4096;

	localparam int FONT_AW  = $clog2(FONT_BYTES);
	localparam int ROW_W    = $clog2(GLYPH_HEIGHT);
	localparam int FIRST_W  = 16;
	localparam int CODE_W   = 8;
	localparam int POS_W    = 11;
	localparam int DIM_W    = 12;
	localparam int ADDR_W   = 32;
	localparam int COLOR_W  = 8;
	localparam int PROD_W   = POS_W + DIM_W;
	localparam int CFG_IW   = 2;

	localparam logic [DIM_W-1:0]   WIDTH_RST  = DIM_W'(800);
	localparam logic [DIM_W-1:0]   HEIGHT_RST = DIM_W'(600);
	localparam logic [ADDR_W-1:0]  BASE_RST   = 32'h000A_0000;
	localparam logic [COLOR_W-1:0] CURSOR_COLOR = COLOR_W'(15);

	typedef enum logic [1:0] {
		OP_LOAD       = 2'd0,
		OP_PUT_CURSOR = 2'd1,
		OP_PUT_POS    = 2'd2,
		OP_NONE       = 2'd3
	} bfr_op_t;

	typedef enum logic [CFG_IW-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_BASE   = 2'd2
	} bfr_cfg_t;

	typedef struct packed {
		logic mul;
		logic sum;
		logic step;
	} bfr_addr_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/bitmap_font_text_renderer_unit.sv @@
// Bitmap font text renderer top level: font store memory, cursor, request sequencer
// and registered row-write outputs. Depends on bfr_pkg and bfr_row_addr.
// The first row write is registered out of ST_RUN after the ST_MUL and ST_SUM setup states,
// then one row a cycle. A drawing request keeps busy high through the multiply and sum setup
// states and 16 glyph rows through the single font memory read port.
// Loads and op 3 never raise busy. Results cannot be stalled.
// Reset: cursor to zero, configuration registers to defaults; the font store is not cleared.
`default_nettype none
module bitmap_font_text_renderer_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	output logic                           busy,
	input  wire [1:0]                      op,
	input  wire [bfr_pkg::CODE_W-1:0]      char_code,
	input  wire [bfr_pkg::POS_W-1:0]       pos_x,
	input  wire [bfr_pkg::POS_W-1:0]       pos_y,
	input  wire [bfr_pkg::COLOR_W-1:0]     color,
	input  wire [11:0]                     font_index,
	input  wire [7:0]                      font_byte,
	input  wire                            cfg_we,
	input  wire [bfr_pkg::CFG_IW-1:0]      cfg_index,
	input  wire [bfr_pkg::ADDR_W-1:0]      cfg_data,
	output logic                           row_valid,
	output logic [bfr_pkg::ADDR_W-1:0]     row_address,
	output logic [7:0]                     pixel_mask,
	output logic [bfr_pkg::COLOR_W-1:0]    pixel_color,
	output logic                           last_row
);
	import bfr_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_SUM, ST_RUN} state_t;

	state_t             state_q;
	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [ADDR_W-1:0]  base_q;
	logic [POS_W-1:0]   cur_x_q;
	logic [POS_W-1:0]   cur_y_q;
	logic [POS_W-1:0]   px_q;
	logic [POS_W-1:0]   py_q;
	logic [COLOR_W-1:0] color_q;
	logic [FIRST_W-1:0] first_q;
	logic [ROW_W-1:0]   row_q;
	logic               valid_q;
	logic [ADDR_W-1:0]  row_addr_q;
	logic [7:0]         mask_q;
	logic [COLOR_W-1:0] pcolor_q;
	logic               last_q;
	logic [7:0]         font_rd_q;
	logic [7:0]         font_mem [FONT_BYTES];

	bfr_op_t            op_e;
	logic               accept;
	logic [DIM_W-1:0]   nx;
	logic [DIM_W-1:0]   ny;
	logic               wrap_x;
	logic [POS_W-1:0]   new_x;
	logic [POS_W-1:0]   new_y;
	logic [FIRST_W-1:0] first;
	logic               glyph_ok;
	logic               mem_we;
	logic [FIRST_W-1:0] rd_row;
	logic [FONT_AW-1:0] rd_addr;
	logic [ADDR_W-1:0]  addr_cur;
	bfr_addr_ctl_t      actl;

	assign op_e   = bfr_op_t'(op);
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// cursor advance and wrap
	always_comb begin
		nx     = DIM_W'(cur_x_q) + DIM_W'(GLYPH_WIDTH);
		wrap_x = (nx >= width_q);
		ny     = wrap_x ? DIM_W'(cur_y_q) + DIM_W'(GLYPH_HEIGHT) : DIM_W'(cur_y_q);
		if (wrap_x) begin
			nx = '0;
		end
		if (ny >= height_q) begin
			ny = '0;
		end
		new_x = nx[POS_W-1:0];
		new_y = ny[POS_W-1:0];
	end

	assign first    = FIRST_W'(char_code) * FIRST_W'(GLYPH_HEIGHT);
	assign glyph_ok = (first + FIRST_W'(GLYPH_HEIGHT)) <= FIRST_W'(FONT_BYTES);
	assign mem_we   = accept && (op_e == OP_LOAD)
	                  && (FIRST_W'(font_index) < FIRST_W'(FONT_BYTES));

	// reads run every cycle but are used only while busy; loads happen only while idle: no overlap
	assign rd_row  = (state_q == ST_SUM) ? '0 : FIRST_W'(row_q) + FIRST_W'(1);
	assign rd_addr = FONT_AW'(first_q + rd_row);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			font_mem[FONT_AW'(font_index)] <= font_byte;
		end
		font_rd_q <= font_mem[rd_addr];
	end

	assign actl.mul  = (state_q == ST_MUL);
	assign actl.sum  = (state_q == ST_SUM);
	assign actl.step = (state_q == ST_RUN);

	bfr_row_addr u_row_addr (
		.clk          (clk),
		.ctl          (actl),
		.pos_x        (px_q),
		.pos_y        (py_q),
		.screen_width (width_q),
		.frame_base   (base_q),
		.row_address  (addr_cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			base_q   <= BASE_RST;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			row_q    <= '0;
			valid_q  <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
			if (cfg_we) begin
				unique case (bfr_cfg_t'(cfg_index))
					CFG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
					CFG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
					CFG_BASE:   base_q   <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						first_q <= first;
						row_q   <= '0;
						unique case (op_e)
							OP_PUT_CURSOR: begin
								cur_x_q <= new_x;
								cur_y_q <= new_y;
								px_q    <= new_x;
								py_q    <= new_y;
								color_q <= CURSOR_COLOR;
								if (glyph_ok) begin
									state_q <= ST_MUL;
								end
							end
							OP_PUT_POS: begin
								px_q    <= pos_x;
								py_q    <= pos_y;
								color_q <= color;
								if (glyph_ok) begin
									state_q <= ST_MUL;
								end
							end
							default: ;
						endcase
					end
				end
				ST_MUL: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_RUN;
				ST_RUN: begin
					valid_q     <= 1'b1;
					row_addr_q  <= addr_cur;
					mask_q      <= font_rd_q;
					pcolor_q    <= color_q;
					row_q       <= row_q + ROW_W'(1);
					if (row_q == ROW_W'(GLYPH_HEIGHT - 1)) begin
						last_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign row_valid   = valid_q;
	assign row_address = row_addr_q;
	assign pixel_mask  = mask_q;
	assign pixel_color = pcolor_q;
	assign last_row    = last_q;

	a_row_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> $past(state_q == ST_RUN))
		else $error("row write without a running draw");

	a_last_has_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_q |-> valid_q)
		else $error("last row flag without row write");

	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (last_q && valid_q))
		else $error("draw ended without its last row");

	a_draw_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && glyph_ok && (op_e == OP_PUT_CURSOR || op_e == OP_PUT_POS))
		|=> (state_q == ST_MUL))
		else $error("draw request did not start");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE))
		else $error("font store written during a draw");

endmodule
`default_nettype wire

@@ rtl/core/bfr_row_addr.sv @@
// Row address unit: forms base + y*width + x for the first glyph row,
// then steps one framebuffer line per row. Depends on bfr_pkg.
`default_nettype none
module bfr_row_addr (
	input  wire                          clk,
	input  bfr_pkg::bfr_addr_ctl_t       ctl,
	input  wire [bfr_pkg::POS_W-1:0]     pos_x,
	input  wire [bfr_pkg::POS_W-1:0]     pos_y,
	input  wire [bfr_pkg::DIM_W-1:0]     screen_width,
	input  wire [bfr_pkg::ADDR_W-1:0]    frame_base,
	output logic [bfr_pkg::ADDR_W-1:0]   row_address
);
	import bfr_pkg::*;

	logic [PROD_W-1:0] prod_s1;
	logic [ADDR_W-1:0] addr_q;

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_s1 <= PROD_W'(pos_y) * PROD_W'(screen_width);
		end
		if (ctl.sum) begin
			addr_q <= frame_base + ADDR_W'(prod_s1) + ADDR_W'(pos_x);
		end else if (ctl.step) begin
			addr_q <= addr_q + ADDR_W'(screen_width);
		end
	end

	assign row_address = addr_q;

endmodule
`default_nettype wire

@@ tb/bitmap_font_text_renderer_unit_test.sv @@
// Testbench for bitmap_font_text_renderer_unit: glyph loads, cursor and positioned puts,
// with row writes checked against a local glyph row predictor across register settings.
// Depends on bfr_pkg and the renderer RTL.
`default_nettype none
module bitmap_font_text_renderer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bfr_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int STALL_LIMIT   = 1000;

	typedef struct packed {
		bfr_op_t            op;
		logic [CODE_W-1:0]  code;
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   y;
		logic [COLOR_W-1:0] color;
		logic [11:0]        index;
		logic [7:0]         fbyte;
	} glyph_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [7:0]         mask;
		logic [COLOR_W-1:0] color;
		logic               last;
	} row_write_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [1:0]           op = '0;
	logic [CODE_W-1:0]    char_code = '0;
	logic [POS_W-1:0]     pos_x = '0;
	logic [POS_W-1:0]     pos_y = '0;
	logic [COLOR_W-1:0]   color = '0;
	logic [11:0]          font_index = '0;
	logic [7:0]           font_byte = '0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IW-1:0]    cfg_index = '0;
	logic [ADDR_W-1:0]    cfg_data = '0;
	logic                 busy;
	logic                 row_valid;
	logic [ADDR_W-1:0]    row_address;
	logic [7:0]           pixel_mask;
	logic [COLOR_W-1:0]   pixel_color;
	logic                 last_row;

	bitmap_font_text_renderer_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .char_code(char_code), .pos_x(pos_x), .pos_y(pos_y), .color(color),
		.font_index(font_index), .font_byte(font_byte),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.row_valid(row_valid), .row_address(row_address), .pixel_mask(pixel_mask),
		.pixel_color(pixel_color), .last_row(last_row)
	);

	// predictor state
	logic [7:0]        font_copy [FONT_BYTES];
	logic [POS_W-1:0]  cur_x = '0;
	logic [POS_W-1:0]  cur_y = '0;
	logic [DIM_W-1:0]  scr_w = WIDTH_RST;
	logic [DIM_W-1:0]  scr_h = HEIGHT_RST;
	logic [ADDR_W-1:0] fb_base = BASE_RST;
	row_write_t        due_rows [$];

	// stimulus state
	glyph_req_t        todo_reqs [$];
	int                reqs_queued = 0;
	int                reqs_accepted = 0;
	logic              req_taken = 1'b0;
	int                hold_off = 0;
	int                calm_left = 0;
	int                stall_cycles = 0;
	int                mismatches = 0;
	logic [15:0]       rows_loaded [256];
	logic [7:0]        ready_codes [$];

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void draw_rows(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
			logic [COLOR_W-1:0] col, logic [CODE_W-1:0] code);
		row_write_t w;
		int first;
		first = int'(code) * GLYPH_HEIGHT;
		if (first + GLYPH_HEIGHT > FONT_BYTES)
			return;
		for (int i = 0; i < GLYPH_HEIGHT; i++) begin
			w.addr  = fb_base + (32'(py) + 32'(i)) * 32'(scr_w) + 32'(px);
			w.mask  = font_copy[first + i];
			w.color = col;
			w.last  = (i == GLYPH_HEIGHT - 1);
			due_rows.push_back(w);
		end
	endfunction

	function automatic void render_request(glyph_req_t r);
		logic [DIM_W-1:0] nx;
		logic [DIM_W-1:0] ny;
		case (r.op)
			OP_LOAD: begin
				if (int'(r.index) < FONT_BYTES)
					font_copy[r.index] = r.fbyte;
			end
			OP_PUT_CURSOR: begin
				// compare unwrapped, then keep 11 bits
				nx = {1'b0, cur_x} + DIM_W'(GLYPH_WIDTH);
				ny = {1'b0, cur_y};
				if (nx >= scr_w) begin
					nx = '0;
					ny = ny + DIM_W'(GLYPH_HEIGHT);
				end
				if (ny >= scr_h)
					ny = '0;
				cur_x = nx[POS_W-1:0];
				cur_y = ny[POS_W-1:0];
				draw_rows(cur_x, cur_y, CURSOR_COLOR, r.code);
			end
			OP_PUT_POS: draw_rows(r.x, r.y, r.color, r.code);
			default: ;
		endcase
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// driver: one request at a time, random hold-off after each accepted request
	always @(negedge clk) begin
		int gap;
		glyph_req_t r;
		if (!(start && !req_taken)) begin
			gap = hold_off;
			if (start) begin
				if (calm_left != 0) begin
					gap = 0;
					calm_left = calm_left - 1;
				end else if ($urandom_range(0, 15) == 0) begin
					gap = 0;
					calm_left = $urandom_range(8, 30);
				end else begin
					gap = $urandom_range(0, 17);
				end
			end
			if (gap != 0) begin
				start <= 1'b0;
				hold_off <= gap - 1;
			end else if (todo_reqs.size() != 0) begin
				r = todo_reqs.pop_front();
				start <= 1'b1;
				op <= r.op;
				char_code <= r.code;
				pos_x <= r.x;
				pos_y <= r.y;
				color <= r.color;
				font_index <= r.index;
				font_byte <= r.fbyte;
				hold_off <= 0;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check row writes, predict accepted requests, watchdog
	always @(posedge clk) begin
		glyph_req_t taken;
		row_write_t want;
		if (row_valid) begin
			if (due_rows.size() == 0) begin
				$display("%0t: unexpected row write addr %0h mask %0h color %0h last %0b",
					$time, row_address, pixel_mask, pixel_color, last_row);
				mismatches++;
			end else begin
				want = due_rows.pop_front();
				compare_field("row_address", want.addr, row_address);
				compare_field("pixel_mask", 32'(want.mask), 32'(pixel_mask));
				compare_field("pixel_color", 32'(want.color), 32'(pixel_color));
				compare_field("last_row", 32'(want.last), 32'(last_row));
			end
		end
		if (start && !busy) begin
			taken.op    = bfr_op_t'(op);
			taken.code  = char_code;
			taken.x     = pos_x;
			taken.y     = pos_y;
			taken.color = color;
			taken.index = font_index;
			taken.fbyte = font_byte;
			render_request(taken);
			reqs_accepted <= reqs_accepted + 1;
		end
		req_taken <= start && !busy;
		if ((start && !busy) || row_valid) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout, %0d row writes outstanding", $time, due_rows.size());
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic glyph_req_t random_req(bfr_op_t o);
		glyph_req_t r;
		r.op    = o;
		r.code  = (ready_codes.size() != 0) ?
			ready_codes[$urandom_range(0, ready_codes.size() - 1)] : 8'($urandom);
		r.x     = POS_W'($urandom);
		r.y     = POS_W'($urandom);
		r.color = COLOR_W'($urandom);
		r.index = 12'($urandom);
		r.fbyte = 8'($urandom);
		return r;
	endfunction

	task automatic queue_req(glyph_req_t r);
		logic [7:0] g;
		if (r.op == OP_LOAD) begin
			g = r.index[11:4];
			if (rows_loaded[g] != 16'hFFFF) begin
				rows_loaded[g][r.index[3:0]] = 1'b1;
				if (rows_loaded[g] == 16'hFFFF)
					ready_codes.push_back(g);
			end
		end
		todo_reqs.push_back(r);
		reqs_queued++;
	endtask

	task automatic load_glyph(logic [7:0] code);
		glyph_req_t r;
		for (int i = 0; i < GLYPH_HEIGHT; i++) begin
			r = random_req(OP_LOAD);
			r.index = {code, 4'(i)};
			case ($urandom_range(0, 7))
				0: r.fbyte = 8'h00;
				1: r.fbyte = 8'hFF;
				default: ;
			endcase
			queue_req(r);
		end
	endtask

	task automatic put_char(bfr_op_t o, logic [7:0] code, logic [POS_W-1:0] x,
			logic [POS_W-1:0] y, logic [COLOR_W-1:0] col);
		glyph_req_t r;
		r = random_req(o);
		r.code  = code;
		r.x     = x;
		r.y     = y;
		r.color = col;
		queue_req(r);
	endtask

	task automatic write_reg(bfr_cfg_t idx, logic [ADDR_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_WIDTH:  scr_w = val[DIM_W-1:0];
			CFG_HEIGHT: scr_h = val[DIM_W-1:0];
			default:    fb_base = val;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// registers change only with nothing in flight
	task automatic settle();
		while (reqs_accepted != reqs_queued || due_rows.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_screen(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, logic [ADDR_W-1:0] b);
		settle();
		write_reg(CFG_WIDTH, {20'($urandom), w});
		write_reg(CFG_HEIGHT, {20'($urandom), h});
		write_reg(CFG_BASE, b);
	endtask

	task automatic random_mix(int n);
		int made;
		int sel;
		made = 0;
		while (made < n) begin
			sel = $urandom_range(0, 99);
			if (sel < 8) begin
				load_glyph(8'($urandom));
				made += GLYPH_HEIGHT;
			end else begin
				if (sel < 22)
					queue_req(random_req(OP_LOAD));
				else if (sel < 52)
					queue_req(random_req(OP_PUT_CURSOR));
				else if (sel < 95)
					queue_req(random_req(OP_PUT_POS));
				else
					queue_req(random_req(OP_NONE));
				made++;
			end
		end
	endtask

	initial begin
		glyph_req_t r;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		for (int i = 0; i < 256; i++)
			rows_loaded[i] = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults; glyphs 0, 0x41 and 255 first
		for (int i = 0; i < GLYPH_HEIGHT; i++) begin
			r = random_req(OP_LOAD);
			r.index = 12'(i);
			r.fbyte = (i == 0) ? 8'hFF : (i == 1) ? 8'h80 : (i == 2) ? 8'h01 :
				(i == 3) ? 8'h00 : 8'($urandom);
			queue_req(r);
		end
		load_glyph(8'h41);
		load_glyph(8'hFF);
		put_char(OP_PUT_POS, 8'h00, '0, '0, '0);
		put_char(OP_PUT_POS, 8'hFF, '1, '1, '1);
		put_char(OP_PUT_POS, 8'h41, POS_W'($urandom), POS_W'($urandom), 8'($urandom));
		put_char(OP_PUT_CURSOR, 8'h00, '0, '0, '0);
		put_char(OP_PUT_CURSOR, 8'hFF, '0, '0, '0);
		queue_req(random_req(OP_NONE));
		r = random_req(OP_LOAD);
		r.index = 12'd5;
		r.fbyte = 8'h5A;
		queue_req(r);
		put_char(OP_PUT_POS, 8'h00, 11'd3, 11'd7, 8'h0F);

		// one-glyph screen: cursor wraps on every put
		set_screen(12'd8, 12'd16, 32'h0);
		repeat (4) put_char(OP_PUT_CURSOR, 8'h41, '0, '0, '0);
		put_char(OP_PUT_POS, 8'hFF, '1, '0, 8'hA5);

		// zero width and height, address wrap past the top
		set_screen(12'd0, 12'd0, 32'hFFFF_FFFF);
		repeat (2) put_char(OP_PUT_CURSOR, 8'h00, '0, '0, '0);
		put_char(OP_PUT_POS, 8'h41, 11'd1, '0, 8'h5A);

		set_screen(12'd2048, 12'd2048, 32'hFFFF_FFF0);
		put_char(OP_PUT_POS, 8'hFF, '1, '1, 8'h3C);
		repeat (2) put_char(OP_PUT_CURSOR, 8'hFF, '0, '0, '0);
		random_mix(26);

		set_screen('1, '1, $urandom);
		random_mix(26);

		for (int p = 0; p < 6; p++) begin
			w = ($urandom_range(0, 1) == 0) ? DIM_W'($urandom_range(8, 64)) :
				DIM_W'($urandom_range(8, 2048));
			h = ($urandom_range(0, 1) == 0) ? DIM_W'($urandom_range(16, 64)) :
				DIM_W'($urandom_range(16, 2048));
			set_screen(w, h, $urandom);
			random_mix(26);
		end

		settle();
		if (mismatches == 0 && due_rows.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/bfr_pkg.sv
rtl/core/bfr_row_addr.sv
rtl/core/bitmap_font_text_renderer_unit.sv
tb/bitmap_font_text_renderer_unit_test.sv
